// ===== src/wmal_pkg.sv =====
// ----------------------------------------------------------------------------
// wmal_pkg
// Shared types and constants for the weighted moving average level block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmal_pkg;

	localparam int THR_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int LEVEL_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = CFG_IDX_W'(1);

	localparam logic [THR_W-1:0] LOW_THR_RESET  = THR_W'(15);
	localparam logic [THR_W-1:0] HIGH_THR_RESET = THR_W'(80);

	localparam logic [LEVEL_W-1:0] LVL_SILENT = LEVEL_W'(0);
	localparam logic [LEVEL_W-1:0] LVL_LOW    = LEVEL_W'(1);
	localparam logic [LEVEL_W-1:0] LVL_MEDIUM = LEVEL_W'(2);
	localparam logic [LEVEL_W-1:0] LVL_HIGH   = LEVEL_W'(3);

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [THR_W-1:0]     data;
	} cfg_wr_t;

endpackage

`default_nettype wire

// ===== src/wmal_window.sv =====
// ----------------------------------------------------------------------------
// wmal_window
// Sample shift line with running total and weighted sum, updated per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module wmal_window #(
	parameter int WINDOW     = 5,
	parameter int COUNT_BITS = 16,
	parameter int SUM_W      = 20
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic [COUNT_BITS-1:0] fresh,
	output logic      [SUM_W-1:0]      acc_next
);

	localparam int TOTAL_W = COUNT_BITS + $clog2(WINDOW + 1);
	localparam int EXT_W   = SUM_W + 1;
	localparam int TEXT_W  = TOTAL_W + 1;

	logic [COUNT_BITS-1:0] ring_q [WINDOW];
	logic [TOTAL_W-1:0]    total_q;
	logic [SUM_W-1:0]      acc_q;
	logic [EXT_W-1:0]      acc_ext;
	logic [TEXT_W-1:0]     total_ext;
	logic [TOTAL_W-1:0]    total_next;

	// newest weighted WINDOW, everyone else drops one weight
	assign acc_ext = EXT_W'(acc_q) + EXT_W'(fresh) * EXT_W'(WINDOW) - EXT_W'(total_q);
	assign acc_next = acc_ext[SUM_W-1:0];

	assign total_ext  = TEXT_W'(total_q) + TEXT_W'(fresh) - TEXT_W'(ring_q[WINDOW-1]);
	assign total_next = total_ext[TOTAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			total_q <= '0;
		end else if (step) begin
			acc_q   <= acc_next;
			total_q <= total_next;
		end
	end

	for (genvar i = 0; i < WINDOW; i++) begin : g_tap
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ring_q[i] <= '0;
			end else if (step) begin
				if (i == 0) begin
					ring_q[i] <= fresh;
				end else begin
					ring_q[i] <= ring_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	a_acc_covers_total: assert property (@(posedge clk) disable iff (!arst_n)
		EXT_W'(acc_q) >= EXT_W'(total_q))
		else $error("weighted sum below window total");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(acc_q) && $stable(total_q))
		else $error("window state moved without a step");

	a_total_tracks_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q == '0) |-> (acc_q == '0))
		else $error("empty window with nonzero weighted sum");

endmodule

`default_nettype wire

// ===== src/wmal_classify.sv =====
// ----------------------------------------------------------------------------
// wmal_classify
// Threshold registers, kept pre-scaled by the divisor, and level compare.
// ----------------------------------------------------------------------------
`default_nettype none

module wmal_classify #(
	parameter int DIVISOR = 15,
	parameter int SUM_W   = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wmal_pkg::cfg_wr_t             cfg,
	input  wire logic [SUM_W-1:0]              sum,
	output logic      [wmal_pkg::LEVEL_W-1:0]  level
);

	localparam int SCALED_W = wmal_pkg::THR_W + $clog2(DIVISOR + 1);
	localparam int CMP_W    = (SCALED_W > SUM_W) ? SCALED_W : SUM_W;

	logic [SCALED_W-1:0] low_scaled_q;
	logic [SCALED_W-1:0] high_scaled_q;
	logic [SCALED_W-1:0] wr_scaled;
	logic [CMP_W-1:0]    sum_ext;

	assign wr_scaled = SCALED_W'(cfg.data) * SCALED_W'(DIVISOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_scaled_q  <= SCALED_W'(wmal_pkg::LOW_THR_RESET) * SCALED_W'(DIVISOR);
			high_scaled_q <= SCALED_W'(wmal_pkg::HIGH_THR_RESET) * SCALED_W'(DIVISOR);
		end else if (cfg.valid) begin
			case (cfg.index)
				wmal_pkg::REG_LOW_THR:  low_scaled_q  <= wr_scaled;
				wmal_pkg::REG_HIGH_THR: high_scaled_q <= wr_scaled;
				default: ;
			endcase
		end
	end

	assign sum_ext = CMP_W'(sum);

	// ties take the lower level
	always_comb begin
		if (sum == '0) begin
			level = wmal_pkg::LVL_SILENT;
		end else if (sum_ext <= CMP_W'(low_scaled_q)) begin
			level = wmal_pkg::LVL_LOW;
		end else if (sum_ext <= CMP_W'(high_scaled_q)) begin
			level = wmal_pkg::LVL_MEDIUM;
		end else begin
			level = wmal_pkg::LVL_HIGH;
		end
	end

endmodule

`default_nettype wire

// ===== src/weighted_moving_average_level_top.sv =====
// ----------------------------------------------------------------------------
// weighted_moving_average_level_top
// Linear weighted moving average of packet counts with a four-way level.
// ----------------------------------------------------------------------------
// One packet count per beat in, one weighted sum and level per beat out. The
// block takes a new count every cycle while the output is not stalled; an
// accepted count passes the input register, then the window update and
// threshold compare into the result register. The running total and weighted
// sum are updated together in that step. Thresholds are stored already
// multiplied by WINDOW*(WINDOW+1)/2, so the compare needs no division; write
// them only while no beat is in flight. The window starts zero-filled.
`default_nettype none

module weighted_moving_average_level_top #(
	parameter int  WINDOW     = 5,
	parameter int  COUNT_BITS = 16,
	localparam int DIVISOR    = WINDOW * (WINDOW + 1) / 2,
	localparam int SUM_W      = COUNT_BITS + $clog2(DIVISOR + 1)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,

	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [COUNT_BITS-1:0]            packet_count,

	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [SUM_W-1:0]                 weighted_sum,
	output logic      [wmal_pkg::LEVEL_W-1:0]     activity_level,

	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [wmal_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [wmal_pkg::THR_W-1:0]       cfg_data
);

	logic                          valid_s1;
	logic [COUNT_BITS-1:0]         count_s1;
	logic                          valid_s2;
	logic [SUM_W-1:0]              sum_s2;
	logic [wmal_pkg::LEVEL_W-1:0]  level_s2;

	logic                          adv2;
	logic                          step;
	logic [SUM_W-1:0]              acc_next;
	logic [wmal_pkg::LEVEL_W-1:0]  level_next;
	wmal_pkg::cfg_wr_t             cfg_wr;

	assign adv2     = !valid_s2 || out_ready;
	assign step     = adv2 && valid_s1;
	assign in_ready = !valid_s1 || adv2;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			count_s1 <= packet_count;
		end
		if (step) begin
			sum_s2   <= acc_next;
			level_s2 <= level_next;
		end
	end

	wmal_window #(
		.WINDOW     (WINDOW),
		.COUNT_BITS (COUNT_BITS),
		.SUM_W      (SUM_W)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.fresh    (count_s1),
		.acc_next (acc_next)
	);

	wmal_classify #(
		.DIVISOR (DIVISOR),
		.SUM_W   (SUM_W)
	) u_classify (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_wr),
		.sum    (acc_next),
		.level  (level_next)
	);

	assign out_valid      = valid_s2;
	assign weighted_sum   = sum_s2;
	assign activity_level = level_s2;

	a_silent_iff_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((sum_s2 == '0) == (level_s2 == wmal_pkg::LVL_SILENT)))
		else $error("silent level does not match zero sum");

	a_stall_keeps_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(count_s1))
		else $error("stage one lost a beat while stalled");

	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("stepped beat did not reach the result register");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the weighted moving average level block.
// ----------------------------------------------------------------------------
// Packet counts are queued by a stimulus process and offered by a driver with
// random gaps. A receiver stalls at random, once for a long stretch. Every
// accepted count runs through a local model of the window and thresholds, and
// the monitor checks each result beat against the oldest prediction. Phases
// with different thresholds are separated by idle points where the registers
// are rewritten.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          WIN        = 5;
	localparam int          CNT_W      = 16;
	localparam int unsigned DIV        = WIN * (WIN + 1) / 2;
	localparam int          SUM_W      = CNT_W + $clog2(DIV + 1);
	localparam int          TOTAL_W    = CNT_W + $clog2(WIN);
	localparam int          LATENCY    = 2;
	localparam int          LONG_HOLD  = 150;
	localparam int          PHASES     = 10;
	localparam int          PHASE_LEN  = 125;
	localparam int          MAX_REPORT = 10;
	localparam int          THR_BITS   = wmal_pkg::THR_W;
	localparam int          IDX_BITS   = wmal_pkg::CFG_IDX_W;
	localparam int          LVL_BITS   = wmal_pkg::LEVEL_W;

	localparam logic [IDX_BITS-1:0] REG_SPARE_2 = IDX_BITS'(2);
	localparam logic [IDX_BITS-1:0] REG_SPARE_3 = IDX_BITS'(3);

	localparam logic [CNT_W-1:0] DIRECTED [24] = '{
		16'd0, 16'd45, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
		16'd240, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd241,
		16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		16'd0, 16'd0, 16'd0, 16'd0, 16'd0
	};

	typedef struct packed {
		logic [SUM_W-1:0]    sum;
		logic [LVL_BITS-1:0] level;
	} avg_result_t;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [CNT_W-1:0]     packet_count = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [SUM_W-1:0]     weighted_sum;
	logic [LVL_BITS-1:0]  activity_level;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [IDX_BITS-1:0]  cfg_index    = '0;
	logic [THR_BITS-1:0]  cfg_data     = '0;

	logic [CNT_W-1:0] pending_counts [$];
	avg_result_t      expected_results [$];

	// window model
	logic [CNT_W-1:0]    window_ring [WIN] = '{default: '0};
	logic [TOTAL_W-1:0]  ring_total        = '0;
	logic [SUM_W-1:0]    weighted_acc      = '0;
	int                  ring_slot         = 0;
	logic [THR_BITS-1:0] low_thr           = wmal_pkg::LOW_THR_RESET;
	logic [THR_BITS-1:0] high_thr          = wmal_pkg::HIGH_THR_RESET;

	bit in_taken   = 1'b0;
	bit tx_steady  = 1'b0;
	bit rx_steady  = 1'b0;
	bit hold_req   = 1'b0;
	int gap_left   = 0;
	int hold_left  = 0;
	int mismatch_count = 0;

	weighted_moving_average_level_top #(
		.WINDOW     (WIN),
		.COUNT_BITS (CNT_W)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.packet_count   (packet_count),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.weighted_sum   (weighted_sum),
		.activity_level (activity_level),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int idle_len();
		if ($urandom_range(0, 9) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic avg_result_t advance_window(input logic [CNT_W-1:0] cnt);
		logic [31:0] acc_next;
		avg_result_t res;
		acc_next = 32'(weighted_acc) + WIN * cnt - 32'(ring_total);
		ring_total = ring_total + cnt - window_ring[ring_slot];
		window_ring[ring_slot] = cnt;
		ring_slot = (ring_slot + 1) % WIN;
		weighted_acc = acc_next[SUM_W-1:0];
		res.sum = weighted_acc;
		if (weighted_acc == '0)
			res.level = wmal_pkg::LVL_SILENT;
		else if (32'(weighted_acc) <= 32'(low_thr) * DIV)
			res.level = wmal_pkg::LVL_LOW;
		else if (32'(weighted_acc) <= 32'(high_thr) * DIV)
			res.level = wmal_pkg::LVL_MEDIUM;
		else
			res.level = wmal_pkg::LVL_HIGH;
		return res;
	endfunction

	// repeats let the window settle on one value, so exact ties come up
	function automatic logic [CNT_W-1:0] next_count(input logic [CNT_W-1:0] prev,
			input logic [THR_BITS-1:0] lo, input logic [THR_BITS-1:0] hi);
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 6)
			return prev;
		else if (pick < 9)
			return CNT_W'(lo + $urandom_range(0, 2) - 1);
		else if (pick < 12)
			return CNT_W'(hi + $urandom_range(0, 2) - 1);
		else if (pick == 12)
			return '0;
		else if (pick == 13)
			return '1;
		else if (pick < 16)
			return CNT_W'($urandom_range(0, 200));
		return CNT_W'($urandom);
	endfunction

	// driver
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_counts.size() != 0) begin
				in_valid     <= 1'b1;
				packet_count <= pending_counts.pop_front();
				gap_left     <= (tx_steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  <= 1'b0;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (rx_steady || $urandom_range(0, 2) != 0) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b0;
			hold_left <= idle_len() - 1;
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		avg_result_t want;
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready)
			expected_results.push_back(advance_window(packet_count));
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				if (mismatch_count < MAX_REPORT)
					$display("%0t: result beat with nothing expected: sum %0d level %0d",
						$realtime, weighted_sum, activity_level);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (weighted_sum !== want.sum || activity_level !== want.level) begin
					if (mismatch_count < MAX_REPORT)
						$display("%0t: mismatch: sum exp %0d got %0d, level exp %0d got %0d",
							$realtime, want.sum, weighted_sum, want.level, activity_level);
					mismatch_count++;
				end
			end
		end
	end

	task automatic write_reg(input logic [IDX_BITS-1:0] idx,
			input logic [THR_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == wmal_pkg::REG_LOW_THR)
			low_thr = val;
		else if (idx == wmal_pkg::REG_HIGH_THR)
			high_thr = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		do @(posedge clk);
		while (pending_counts.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [THR_BITS-1:0] lo;
		logic [THR_BITS-1:0] hi;
		logic [CNT_W-1:0]    value;
		value = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		@(posedge clk);
		foreach (DIRECTED[i])
			pending_counts.push_back(DIRECTED[i]);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					lo = '0;
					hi = '0;
				end
				1: begin
					lo = '1;
					hi = '1;
				end
				2: begin
					lo = THR_BITS'(1000);
					hi = THR_BITS'(10);
				end
				3: begin
					lo = wmal_pkg::LOW_THR_RESET;
					hi = wmal_pkg::HIGH_THR_RESET;
				end
				8: begin
					lo = THR_BITS'($urandom);
					hi = THR_BITS'($urandom);
				end
				default: begin
					lo = THR_BITS'($urandom_range(0, 3000));
					hi = THR_BITS'(lo + $urandom_range(0, 30000));
				end
			endcase
			write_reg(wmal_pkg::REG_LOW_THR, lo);
			write_reg(wmal_pkg::REG_HIGH_THR, hi);
			if (phase == 2)
				write_reg(REG_SPARE_2, THR_BITS'($urandom));
			if (phase == 6)
				write_reg(REG_SPARE_3, THR_BITS'($urandom));

			@(posedge clk);
			tx_steady = (phase == 3 || phase == 5 || phase == 7);
			rx_steady = (phase == 3 || phase == 7);
			if (phase == 5)
				hold_req = 1'b1;
			repeat (PHASE_LEN) begin
				value = next_count(value, lo, hi);
				pending_counts.push_back(value);
			end
			settle();
		end

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
